// File: rtl/core/assert_macros.svh
// Assertion macros used by the top level of the bag table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define MSBT_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Checked on every rising clock edge, reset included.
`define MSBT_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// File: rtl/core/msbt_pkg.sv
// Package with the request codes, status codes and result type of the bag table.
package msbt_pkg;

  localparam int unsigned DefBagDepth  = 32;
  localparam int unsigned DefValueBits = 32;
  localparam int unsigned ItemBits     = 32;
  localparam int unsigned CountBits    = 6;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_ERASE_ONE = 2'd1,
    OP_ERASE_ALL = 2'd2,
    OP_COUNT     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    status_e              status;
    logic [CountBits-1:0] match_count;
    logic [CountBits-1:0] fill_level;
  } result_t;

endpackage

// File: rtl/core/msbt_mem.sv
// Entry store: one write port and one read port with registered read data.
module msbt_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/core/msbt_ctrl.sv
// Sequencer that runs insert directly and scans the store for erase and count.
module msbt_ctrl #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned SW    = 32,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  msbt_pkg::op_e     op_i,
  input  logic [SW-1:0]     value_i,
  output logic              idle_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  logic [SW-1:0]     mem_rdata_i,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [SW-1:0]     mem_wdata_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output msbt_pkg::result_t res_o
);
  import msbt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e        state_q;
  op_e           op_q;
  logic [SW-1:0] val_q;
  logic [CW-1:0] total_q;
  logic [CW-1:0] rd_idx_q;
  logic [CW-1:0] wr_idx_q;
  logic [CW-1:0] cnt_q;
  logic          pend_q;
  logic          removed_q;
  result_t       res_q;

  logic          full;
  logic          issue;
  logic          hit;
  logic          keep;
  logic          erase;
  logic          scan_end;
  logic [CW-1:0] new_total;

  always_comb begin
    full      = (total_q == CW'(DEPTH));
    issue     = (state_q == S_SCAN) && (rd_idx_q < total_q);
    hit       = pend_q && (mem_rdata_i == val_q);
    erase     = (op_q == OP_ERASE_ONE) || (op_q == OP_ERASE_ALL);
    // After the first copy is gone, erase-one keeps every later copy.
    keep      = !hit || ((op_q == OP_ERASE_ONE) && removed_q);
    scan_end  = (state_q == S_SCAN) && !issue && !pend_q;
    new_total = erase ? wr_idx_q : total_q;

    mem_re_o    = 1'b0;
    mem_raddr_o = rd_idx_q[AW-1:0];
    mem_we_o    = 1'b0;
    mem_waddr_o = wr_idx_q[AW-1:0];
    mem_wdata_o = mem_rdata_i;

    if (state_q == S_IDLE) begin
      if (start_i && (op_i == OP_INSERT) && !full) begin
        mem_we_o    = 1'b1;
        mem_waddr_o = total_q[AW-1:0];
        mem_wdata_o = value_i;
      end
    end else if (state_q == S_SCAN) begin
      mem_re_o = issue;
      // Compaction: surviving entries are written back below the read pointer.
      if (pend_q && erase && keep) begin
        mem_we_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      total_q   <= '0;
      pend_q    <= 1'b0;
      rd_idx_q  <= '0;
      wr_idx_q  <= '0;
      cnt_q     <= '0;
      removed_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            op_q      <= op_i;
            val_q     <= value_i;
            rd_idx_q  <= '0;
            wr_idx_q  <= '0;
            cnt_q     <= '0;
            removed_q <= 1'b0;
            pend_q    <= 1'b0;
            if (op_i == OP_INSERT) begin
              res_q.match_count <= '0;
              if (!full) begin
                total_q          <= CW'(total_q + 1'b1);
                res_q.status     <= ST_DONE;
                res_q.fill_level <= CountBits'(CW'(total_q + 1'b1));
              end else begin
                res_q.status     <= ST_FULL;
                res_q.fill_level <= CountBits'(total_q);
              end
              state_q <= S_FINISH;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          pend_q <= issue;
          if (issue) begin
            rd_idx_q <= CW'(rd_idx_q + 1'b1);
          end
          if (pend_q) begin
            if (erase) begin
              if (keep) begin
                wr_idx_q <= CW'(wr_idx_q + 1'b1);
              end else begin
                cnt_q     <= CW'(cnt_q + 1'b1);
                removed_q <= 1'b1;
              end
            end else if (hit) begin
              cnt_q <= CW'(cnt_q + 1'b1);
            end
          end
          if (scan_end) begin
            total_q <= new_total;
            if ((op_q == OP_ERASE_ONE) && (cnt_q == '0)) begin
              res_q.status <= ST_NOT_FOUND;
            end else begin
              res_q.status <= ST_DONE;
            end
            res_q.match_count <= CountBits'(cnt_q);
            res_q.fill_level  <= CountBits'(new_total);
            state_q           <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_FINISH);
  assign res_o       = res_q;

endmodule

// File: rtl/core/multiset_bag_table.sv
// Top level of the fixed-capacity multiset bag table.
//
// This block keeps an unordered bag of up to BAG_DEPTH values in a single
// synchronous memory, with the fill level held in a register. Each request
// transfer carries an operation code (insert, erase one copy, erase all copies,
// count copies) and a value, and produces exactly one result transfer with a
// status, a match count and the fill level after the request. An insert into
// a bag that is not full writes its value at the end of the bag in the cycle
// the request is taken. Erase and count requests walk the stored entries
// through the memory's single read port, one entry per cycle; that sequential
// scan sets the rate of erase and count requests.
// Erase requests compact the bag during the same pass by writing each surviving
// entry back at a lower write pointer, so no separate move step is needed. The
// order of stored entries is not visible at the ports. A new request is taken
// once the previous result has moved into the output register, even while it
// still waits there. No clearing pass is needed after reset.
module multiset_bag_table #(
  parameter int unsigned BAG_DEPTH  = msbt_pkg::DefBagDepth,
  parameter int unsigned VALUE_BITS = msbt_pkg::DefValueBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    req_type_i,
  input  logic [msbt_pkg::ItemBits-1:0] item_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [msbt_pkg::CountBits-1:0] match_count_o,
  output logic [msbt_pkg::CountBits-1:0] fill_level_o
);
  import msbt_pkg::*;

`include "assert_macros.svh"

  // Stored values keep only the low bits of the item that the bag compares.
  localparam int unsigned SW = (VALUE_BITS < ItemBits) ? VALUE_BITS : ItemBits;
  localparam int unsigned AW = $clog2(BAG_DEPTH);
  localparam int unsigned CW = $clog2(BAG_DEPTH + 1);

  logic          start;
  logic          idle;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [SW-1:0] mem_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [SW-1:0] mem_wdata;
  logic          res_valid;
  logic          res_ready;
  result_t       res;

  logic          out_valid_q;
  result_t       out_res_q;

  // Requests are taken whenever the sequencer is free.
  assign in_ready_o = idle;
  assign start      = in_valid_i && in_ready_o;

  // The output register frees up in the same cycle its result is taken.
  assign res_ready = !out_valid_q || out_ready_i;

  msbt_ctrl #(
    .DEPTH(BAG_DEPTH),
    .SW   (SW),
    .AW   (AW),
    .CW   (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .op_i       (op_e'(req_type_i)),
    .value_i    (item_value_i[SW-1:0]),
    .idle_o     (idle),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  msbt_mem #(
    .DEPTH(BAG_DEPTH),
    .WIDTH(SW),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata)
  );

  // Output register: holds one finished result until it is transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = 2'(out_res_q.status);
  assign match_count_o = out_res_q.match_count;
  assign fill_level_o  = out_res_q.fill_level;

  // A result blocked by a full output register stays pending in the sequencer.
  `MSBT_ASSERT(a_res_held, clk_i, rst_ni, (res_valid && !res_ready) |=> res_valid)
  // Once a request is taken the block is busy for at least the next cycle.
  `MSBT_ASSERT(a_busy_after_start, clk_i, rst_ni, start |=> !in_ready_o)
  // A failed erase-one never reports a removed copy.
  `MSBT_ASSERT(a_not_found_zero, clk_i, rst_ni,
    (out_valid_o && (status_o == ST_NOT_FOUND)) |-> (match_count_o == '0))
  // Reset leaves no result pending at the output.
  `MSBT_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_o)

endmodule

// File: test/multiset_bag_table_test.sv
// Self-checking testbench for the multiset bag table with random handshake pacing.
module multiset_bag_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import msbt_pkg::*;

  localparam int BagDepth = DefBagDepth;
  localparam int PoolSize = 4;
  localparam int RandomItems = 550;
  localparam int CycleLimit = 300000;

  // Sides of the handshake, used to keep separate idle histories.
  localparam int SIDE_SEND = 0;
  localparam int SIDE_RECV = 1;

  // Kinds of random phases. A fill phase mostly inserts, so the bag climbs
  // toward full; a drain phase mostly erases and counts; a mixed phase
  // spreads evenly over all operations.
  localparam int PHASE_FILL = 0;
  localparam int PHASE_DRAIN = 1;
  localparam int PHASE_MIXED = 2;

  typedef struct {
    op_e         op;
    logic [31:0] value;
    bit          drain_first;
  } bag_req_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b1;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           req_type_i = OP_INSERT;
  logic [ItemBits-1:0]  item_value_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [1:0]           status_o;
  logic [CountBits-1:0] match_count_o;
  logic [CountBits-1:0] fill_level_o;

  multiset_bag_table uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .item_value_i (item_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .match_count_o(match_count_o),
    .fill_level_o (fill_level_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Requests waiting to be driven, and the results predicted for requests
  // that have already been transferred but not yet answered.
  bag_req_t request_queue[$];
  result_t  result_queue[$];

  // Our own copy of the bag. The block compacts the store in a different
  // order than we do, but order never shows at the ports: only the number
  // of copies of each value and the fill level matter.
  logic [31:0] bag_contents[BagDepth];
  int          bag_fill = 0;

  logic [31:0] value_pool[PoolSize];

  int error_count = 0;
  int cycle_count = 0;

  // Transfer counters are written only at the rising edge; the falling-edge
  // processes compare them against their own copies to see a transfer.
  int send_count = 0;
  int send_seen = 0;
  int send_gap = 0;
  int recv_count = 0;
  int recv_seen = 0;
  int recv_stall = 0;
  int calm_left[2] = '{0, 0};

  // Number of idle cycles before the next item on one side. Now and then a
  // side enters a calm stretch in which it never idles, so back-to-back
  // transfers are covered as well as long gaps.
  function automatic int draw_wait(int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left[side] = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // Remove the first stored copy of a value by moving the last entry into
  // its slot. Reports whether a copy was found.
  function automatic bit bag_take(logic [31:0] value);
    for (int slot = 0; slot < bag_fill; slot++) begin
      if (bag_contents[slot] == value) begin
        bag_contents[slot] = bag_contents[bag_fill-1];
        bag_fill--;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Apply one request to our bag and return the result it must produce.
  // With the default value width all 32 bits of the value are kept.
  function automatic result_t bag_apply(op_e op, logic [31:0] value);
    result_t res;
    int      hits;
    res.status = ST_DONE;
    hits = 0;
    case (op)
      OP_INSERT: begin
        if (bag_fill < BagDepth) begin
          bag_contents[bag_fill] = value;
          bag_fill++;
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_ERASE_ONE: begin
        if (bag_take(value)) begin
          hits = 1;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      OP_ERASE_ALL: begin
        while (bag_take(value)) hits++;
      end
      default: begin
        for (int slot = 0; slot < bag_fill; slot++) begin
          if (bag_contents[slot] == value) hits++;
        end
      end
    endcase
    res.match_count = CountBits'(hits);
    res.fill_level = CountBits'(bag_fill);
    return res;
  endfunction

  function automatic void add_request(op_e op, logic [31:0] value, bit drain_first);
    bag_req_t req;
    req.op = op;
    req.value = value;
    req.drain_first = drain_first;
    request_queue.push_back(req);
  endfunction

  // Values come mostly from a small pool so that duplicates pile up and
  // erases and counts hit; the rest are wide random values that mostly miss.
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 85) return value_pool[$urandom_range(0, PoolSize-1)];
    return $urandom();
  endfunction

  function automatic op_e pick_op(int kind);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      PHASE_FILL: begin
        if (r < 85) return OP_INSERT;
        return op_e'($urandom_range(1, 3));
      end
      PHASE_DRAIN: begin
        if (r < 40) return OP_ERASE_ONE;
        if (r < 65) return OP_ERASE_ALL;
        if (r < 90) return OP_COUNT;
        return OP_INSERT;
      end
      default: return op_e'($urandom_range(0, 3));
    endcase
  endfunction

  // Driver: presents one request at a time. The slot frees up at the falling
  // edge after a transfer; the next request then follows after its drawn gap.
  // A request marked drain_first is held back until every predicted result
  // has been seen, which lets the block run completely dry at least once.
  always @(negedge clk_i) begin
    bag_req_t next_req;
    if (rst_ni && (!in_valid_i || send_seen != send_count)) begin
      send_seen = send_count;
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (request_queue.size() != 0 &&
                   !(request_queue[0].drain_first && result_queue.size() != 0)) begin
        next_req = request_queue.pop_front();
        in_valid_i <= 1'b1;
        req_type_i <= next_req.op;
        item_value_i <= next_req.value;
        send_gap = draw_wait(SIDE_SEND);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: after each result transfer it draws a stall and holds ready
  // low for that many cycles.
  always @(negedge clk_i) begin
    if (recv_seen != recv_count) begin
      recv_seen = recv_count;
      recv_stall = draw_wait(SIDE_RECV);
    end
    if (recv_stall > 0) begin
      recv_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: at each rising edge, check a result transfer against the oldest
  // prediction, then predict the result of a request transfer. The result
  // side goes first so a result can never be matched to a request that was
  // transferred at the same edge.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        recv_count++;
        if (result_queue.size() == 0) begin
          $error("result transfer with no request outstanding");
          error_count++;
        end else begin
          want = result_queue.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            error_count++;
          end
          if (match_count_o !== want.match_count) begin
            $error("match_count: expected %0d, got %0d", want.match_count, match_count_o);
            error_count++;
          end
          if (fill_level_o !== want.fill_level) begin
            $error("fill_level: expected %0d, got %0d", want.fill_level, fill_level_o);
            error_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        result_queue.push_back(bag_apply(op_e'(req_type_i), item_value_i));
        send_count++;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("multiset_bag_table_test: done, errors");
      $finish;
    end
  end

  initial begin
    int kind;
    int span;
    int total;
    int r;

    // Reset falls at time zero, once every process waits on its edges.
    rst_ni <= 1'b0;

    // Directed opening: every operation on an empty bag, duplicates of both
    // all-zero and all-one values, a miss on a non-empty bag, and erase-all
    // removing several copies at once. The two alternating patterns toggle
    // every value bit.
    add_request(OP_COUNT, 32'h0000_0000, 1'b0);
    add_request(OP_ERASE_ONE, 32'h0000_0000, 1'b0);
    add_request(OP_ERASE_ALL, 32'h0000_0000, 1'b0);
    add_request(OP_INSERT, 32'h0000_0000, 1'b0);
    add_request(OP_INSERT, 32'hFFFF_FFFF, 1'b0);
    add_request(OP_INSERT, 32'h0000_0000, 1'b0);
    add_request(OP_INSERT, 32'h0000_0000, 1'b0);
    add_request(OP_COUNT, 32'h0000_0000, 1'b0);
    add_request(OP_COUNT, 32'hFFFF_FFFF, 1'b0);
    add_request(OP_COUNT, 32'h1234_5678, 1'b0);
    add_request(OP_ERASE_ONE, 32'h0000_0000, 1'b0);
    add_request(OP_ERASE_ONE, 32'hA5A5_A5A5, 1'b0);
    add_request(OP_INSERT, 32'h5A5A_5A5A, 1'b0);
    add_request(OP_INSERT, 32'hFFFF_FFFF, 1'b0);
    add_request(OP_ERASE_ALL, 32'h0000_0000, 1'b0);
    add_request(OP_ERASE_ALL, 32'hFFFF_FFFF, 1'b0);
    add_request(OP_ERASE_ALL, 32'h89AB_CDEF, 1'b0);
    add_request(OP_COUNT, 32'h5A5A_5A5A, 1'b0);
    add_request(OP_ERASE_ONE, 32'h5A5A_5A5A, 1'b0);
    add_request(OP_INSERT, 32'h8000_0000, 1'b0);
    add_request(OP_INSERT, 32'h0000_0001, 1'b0);

    // Random phases. The first is a long fill that is sure to reach a full
    // bag and try inserts beyond it; it starts only after the block drains.
    total = 0;
    while (total < RandomItems) begin
      for (int k = 0; k < PoolSize; k++) begin
        r = $urandom_range(0, 9);
        if (r == 0) value_pool[k] = '0;
        else if (r == 1) value_pool[k] = '1;
        else if (r == 2) value_pool[k] = 32'h1 << $urandom_range(0, 31);
        else value_pool[k] = $urandom();
      end
      if (total == 0) begin
        kind = PHASE_FILL;
        span = 40;
      end else begin
        kind = $urandom_range(PHASE_FILL, PHASE_MIXED);
        span = $urandom_range(8, 40);
      end
      for (int n = 0; n < span; n++) begin
        if (total == 0 && n < BagDepth + 4) begin
          add_request(OP_INSERT, pick_value(), n == 0);
        end else begin
          add_request(pick_op(kind), pick_value(), n == 0 && $urandom_range(0, 3) == 0);
        end
      end
      total += span;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (request_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (result_queue.size() != 0) @(posedge clk_i);
    // This wait outlasts a scan over a full bag, so it is enough
    // for any stray extra result to show up.
    repeat (BagDepth + 8) @(posedge clk_i);

    if (error_count == 0) begin
      $display("multiset_bag_table_test: done, clean");
    end else begin
      $display("multiset_bag_table_test: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/msbt_pkg.sv
rtl/core/msbt_mem.sv
rtl/core/msbt_ctrl.sv
rtl/core/multiset_bag_table.sv
test/multiset_bag_table_test.sv
